// ----- sv/lnts_pkg.sv -----
// Package for the natural log unit: widths, packed stage structs and
// elaboration-time tables (series coefficients, ln breakpoint table).
// No dependencies.
package lnts_pkg;

  localparam int unsigned TABLE_ENTRIES  = 32;
  localparam int unsigned SERIES_TERMS   = 10;
  localparam int unsigned FRACTION_BITS  = 48;
  localparam int unsigned LN_TABLE_TERMS = 24;

  localparam logic [63:0] LN2_Q62   = 64'h2C5C85FDF473DE6B;
  localparam logic [59:0] POS_LIMIT = 60'h7FFFFFFFFFFFFFF;
  localparam logic [59:0] NEG_LIMIT = 60'h800000000000000;

  localparam int unsigned DIV_W   = 55;
  localparam int unsigned QUO_W   = 62;
  localparam int unsigned MAG_W   = 75;
  localparam int unsigned MUL_NUM = SERIES_TERMS + 2;

  function automatic int unsigned index_bits();
    int unsigned l;
    l = 0;
    for (int i = 0; i < 8; i++) begin
      if ((64'd2 << l) <= 64'(TABLE_ENTRIES)) l++;
    end
    return l;
  endfunction

  localparam int unsigned IDX_BITS = index_bits();
  localparam int unsigned TSIZE    = 1 << IDX_BITS;
  localparam int unsigned SH       = 52 - IDX_BITS;
  localparam int unsigned RSH      = 62 - FRACTION_BITS;

  function automatic logic [63:0] coef_q62(int unsigned n);
    logic [64:0] rem;
    logic [64:0] den;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    den = 65'(2 * n + 1);
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], (i == 63)};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] div_q62(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = {1'b0, num};
    q   = '0;
    for (int i = 0; i < 62; i++) begin
      rem = {rem[63:0], 1'b0};
      q   = {q[62:0], 1'b0};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atanh2_q62(logic [63:0] b, int unsigned terms);
    logic [63:0] bsq;
    logic [63:0] poly;
    bsq  = mul_q62(b, b);
    poly = coef_q62(terms);
    for (int n = int'(terms); n > 0; n--) begin
      poly = mul_q62(poly, bsq) + coef_q62(n - 1);
    end
    return mul_q62(b, poly);
  endfunction

  typedef logic [TSIZE-1:0][63:0] ln_tab_t;

  function automatic ln_tab_t build_ln_tab();
    ln_tab_t t;
    for (int k = 0; k < int'(TSIZE); k++) begin
      t[k] = atanh2_q62(div_q62(64'(k), 64'(2 * TSIZE + k)), LN_TABLE_TERMS);
    end
    return t;
  endfunction

  localparam ln_tab_t LN_TAB = build_ln_tab();

  typedef struct packed {
    logic                invalid;
    logic                neg;
    logic [10:0]         ae;
    logic [IDX_BITS-1:0] k;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    side_t       side;
    logic [63:0] a;
    logic [63:0] bsq;
  } mctx_t;

endpackage

// ----- sv/lnts_div_stage.sv -----
// One restoring division step of the quotient pipeline, registered.
// Depends on lnts_pkg.
module lnts_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  lnts_pkg::div_t data_i,
  output logic           valid_o,
  output lnts_pkg::div_t data_o
);
  import lnts_pkg::*;

  logic             valid_q;
  div_t             data_q, data_d;
  logic [DIV_W-1:0] rem2;
  logic             ge;

  always_comb begin
    rem2          = {data_i.rem[DIV_W-2:0], 1'b0};
    ge            = rem2 >= data_i.den;
    data_d        = data_i;
    data_d.rem    = ge ? rem2 - data_i.den : rem2;
    data_d.quo    = {data_i.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ----- sv/lnts_mul_stage.sv -----
// Two-stage Q62 multiply-add: 32x32 partial products, then sum and add.
// Depends on lnts_pkg.
module lnts_mul_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [63:0]     x_i,
  input  logic [63:0]     y_i,
  input  logic [63:0]     add_i,
  input  lnts_pkg::mctx_t ctx_i,
  output logic            valid_o,
  output logic [63:0]     res_o,
  output lnts_pkg::mctx_t ctx_o
);
  import lnts_pkg::*;

  logic         v1_q, v2_q;
  logic [63:0]  ll_q, lh_q, hl_q, hh_q, add_q;
  mctx_t        ctx1_q, ctx2_q;
  logic [127:0] full;
  logic [63:0]  res_d, res_q;

  always_comb begin
    full  = {64'b0, ll_q} + ({64'b0, lh_q} << 32) + ({64'b0, hl_q} << 32) + {hh_q, 64'b0};
    res_d = full[125:62] + add_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q   <= {32'b0, x_i[31:0]} * {32'b0, y_i[31:0]};
      lh_q   <= {32'b0, x_i[31:0]} * {32'b0, y_i[63:32]};
      hl_q   <= {32'b0, x_i[63:32]} * {32'b0, y_i[31:0]};
      hh_q   <= {32'b0, x_i[63:32]} * {32'b0, y_i[63:32]};
      add_q  <= add_i;
      ctx1_q <= ctx_i;
      res_q  <= res_d;
      ctx2_q <= ctx1_q;
    end
  end

  assign valid_o = v2_q;
  assign res_o   = res_q;
  assign ctx_o   = ctx2_q;
endmodule

// ----- sv/lnts_post.sv -----
// Result assembly: table add, exponent times ln2, rounding, saturation,
// sign and the output register. Depends on lnts_pkg.
module lnts_post (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  lnts_pkg::side_t    side_i,
  input  logic [63:0]        series_i,
  output logic               valid_o,
  output logic signed [59:0] log_value_o,
  output logic               invalid_o
);
  import lnts_pkg::*;

  localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (RSH - 1);

  logic             v1_q, v2_q, v3_q;
  side_t            s1_q, s2_q;
  logic [63:0]      frac_q;
  logic [MAG_W-1:0] prod_q, mag, wide_d, wide_q;
  logic [59:0]      res_d, res_q;
  logic             inv_q;

  always_comb begin
    mag    = s1_q.neg ? prod_q - MAG_W'(frac_q) : prod_q + MAG_W'(frac_q);
    wide_d = (mag + HALF) >> RSH;
    if (s2_q.neg) begin
      res_d = (wide_q > MAG_W'(NEG_LIMIT)) ? NEG_LIMIT : wide_q[59:0];
      res_d = 60'd0 - res_d;
    end else begin
      res_d = (wide_q > MAG_W'(POS_LIMIT)) ? POS_LIMIT : wide_q[59:0];
    end
    if (s2_q.invalid) res_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q   <= side_i;
      frac_q <= LN_TAB[side_i.k] + series_i;
      prod_q <= MAG_W'(side_i.ae) * MAG_W'(LN2_Q62);
      s2_q   <= s1_q;
      wide_q <= wide_d;
      res_q  <= res_d;
      inv_q  <= s2_q.invalid;
    end
  end

  assign valid_o     = v3_q;
  assign log_value_o = signed'(res_q);
  assign invalid_o   = inv_q;
endmodule

// ----- sv/natural_log_table_series.sv -----
// Top level of the pipelined natural log unit for binary64 arguments.
// Depends on lnts_pkg, lnts_div_stage, lnts_mul_stage, lnts_post.
//
//   channel | valid   | stall   | payload
//   input   | valid_i | stall_o | value_bits_i
//   output  | valid_o | stall_i | log_value_o, invalid_o
//
// Accepts one transaction per cycle unless stalled; the pipeline has one decode stage,
// 62 quotient stages (one bit each), twelve two-stage multipliers, three
// result stages. Reset clears only the valid bits of every stage.
// A stalled result freezes the whole pipeline; bubbles are not squeezed.
module natural_log_table_series (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [63:0]        value_bits_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [59:0] log_value_o,
  output logic               invalid_o
);
  import lnts_pkg::*;

  logic        en;
  logic        dv [QUO_W+1];
  div_t        dd [QUO_W+1];
  logic        mv [MUL_NUM];
  logic [63:0] mres [MUL_NUM];
  mctx_t       mctx [MUL_NUM];
  div_t        dec_d;
  logic        dec_v_q;
  div_t        dec_q;
  logic [10:0] ef;
  logic [51:0] f;

  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  always_comb begin
    ef                 = value_bits_i[62:52];
    f                  = value_bits_i[51:0];
    dec_d.side.invalid = value_bits_i[63] || (ef == 11'd0) || (ef == 11'h7FF);
    dec_d.side.neg     = ef < 11'd1023;
    dec_d.side.ae      = dec_d.side.neg ? 11'd1023 - ef : ef - 11'd1023;
    dec_d.side.k       = f[51:SH];
    dec_d.rem          = DIV_W'(f[SH-1:0]);
    dec_d.den          = (DIV_W'(1) << 53) + DIV_W'(f) + (DIV_W'(f[51:SH]) << SH);
    dec_d.quo          = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_v_q <= 1'b0;
    end else if (en) begin
      dec_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dec_q <= dec_d;
    end
  end

  assign dv[0] = dec_v_q;
  assign dd[0] = dec_q;

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    lnts_div_stage u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(dv[i]),
      .data_i (dd[i]),
      .valid_o(dv[i+1]),
      .data_o (dd[i+1])
    );
  end

  for (genvar j = 0; j < MUL_NUM; j++) begin : g_mul
    logic [63:0] x, y;
    logic        v;
    mctx_t       c;
    if (j == 0) begin : g_sq
      assign v = dv[QUO_W];
      assign x = {2'b0, dd[QUO_W].quo};
      assign y = {2'b0, dd[QUO_W].quo};
      assign c = '{side: dd[QUO_W].side, a: {2'b0, dd[QUO_W].quo}, bsq: 64'd0};
    end else if (j == 1) begin : g_first
      assign v = mv[0];
      assign x = coef_q62(SERIES_TERMS);
      assign y = mres[0];
      assign c = '{side: mctx[0].side, a: mctx[0].a, bsq: mres[0]};
    end else if (j <= int'(SERIES_TERMS)) begin : g_horner
      assign v = mv[j-1];
      assign x = mres[j-1];
      assign y = mctx[j-1].bsq;
      assign c = mctx[j-1];
    end else begin : g_last
      assign v = mv[j-1];
      assign x = mctx[j-1].a;
      assign y = mres[j-1];
      assign c = mctx[j-1];
    end
    lnts_mul_stage u_mul (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(v),
      .x_i    (x),
      .y_i    (y),
      .add_i  ((j >= 1 && j <= int'(SERIES_TERMS)) ?
               coef_q62(SERIES_TERMS - j) : 64'd0),
      .ctx_i  (c),
      .valid_o(mv[j]),
      .res_o  (mres[j]),
      .ctx_o  (mctx[j])
    );
  end

  lnts_post u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (mv[MUL_NUM-1]),
    .side_i     (mctx[MUL_NUM-1].side),
    .series_i   (mres[MUL_NUM-1]),
    .valid_o    (valid_o),
    .log_value_o(log_value_o),
    .invalid_o  (invalid_o)
  );
endmodule
